>>> hw/rtl/lrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_pkg
// shared constants for the learning route forwarder
// ----------------------------------------------------------------------------
package lrf_pkg;

   localparam int LINK_W            = 6;
   localparam int DEF_TABLE_DEPTH   = 64;
   localparam int DEF_ADDR_WIDTH    = 16;
   localparam int DEF_MAX_LINKS     = 32;
   localparam logic [LINK_W-1:0] LINK_COUNT_RESET = 6'd4;

endpackage : lrf_pkg
`default_nettype wire

>>> hw/rtl/lrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : lrf_ram
`default_nettype wire

>>> hw/rtl/learning_route_forwarder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// learning_route_forwarder
// forwarding step of a learning bridge with a sequentially scanned route table
// ----------------------------------------------------------------------------
// Each request transaction carries one frame header (source, destination,
// arrival link). The route table lives in one ram with a single read port; a
// small sequencer walks the learned entries one at a time and a shared compare
// unit checks every entry against the forward pair and the reverse pair in the
// same step, keeping the first hit of each. Each stored entry takes a ram read
// state, then a compare state; a decide state follows, after which the first
// response turns valid. Forwarded frames give one response; floods give one
// response per link, 1 .. link_count (zero counts as one, capped at
// MAX_LINKS), one per cycle while rsp_ready is high, with rsp_last on the
// final one. A new request is taken only after the last response of the
// previous one has been taken. The table needs no clearing pass after reset:
// only entries below the learned count are ever read. link_count is written
// through the csr channel, which is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module learning_route_forwarder
   import lrf_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH,
   parameter int MAX_LINKS   = DEF_MAX_LINKS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [LINK_W-1:0]     csr_link_count,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [ADDR_WIDTH-1:0] req_src_addr,
   input  wire logic [ADDR_WIDTH-1:0] req_dst_addr,
   input  wire logic [LINK_W-1:0]     req_arrival_link,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [LINK_W-1:0]          rsp_send_link,
   output logic                       rsp_flooding,
   output logic                       rsp_last,
   output logic                       rsp_table_full
);

   // widths derived from the parameters
   localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;  // entry index
   localparam int CW  = $clog2(TABLE_DEPTH + 1);                      // entry count
   localparam int LCW = $clog2(MAX_LINKS + 1);                        // flood counter

   // table word layout: {known, out_link, in_link, dst, src}
   localparam int SRC_LO   = 0;
   localparam int DST_LO   = ADDR_WIDTH;
   localparam int IN_LO    = 2 * ADDR_WIDTH;
   localparam int OUT_LO   = IN_LO + LINK_W;
   localparam int KNOWN_B  = OUT_LO + LINK_W;
   localparam int WORD_W   = KNOWN_B + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DECIDE,
      ST_OUT
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              fwd_found_ff, fwd_found_in;
   logic              rev_found_ff, rev_found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LINK_W-1:0] link_count_ff, link_count_in;

   // payload state
   logic [ADDR_WIDTH-1:0] src_ff, src_in;
   logic [ADDR_WIDTH-1:0] dst_ff, dst_in;
   logic [LINK_W-1:0]     arrive_ff, arrive_in;
   logic [IW-1:0]         fidx_ff, fidx_in;
   logic [WORD_W-1:0]     fword_ff, fword_in;
   logic [LINK_W-1:0]     rev_link_ff, rev_link_in;
   logic [LCW-1:0]        flood_cnt_ff, flood_cnt_in;
   logic [LCW-1:0]        flood_n_ff, flood_n_in;
   logic [LINK_W-1:0]     send_link_ff, send_link_in;
   logic                  flooding_ff, flooding_in;
   logic                  last_ff, last_in;
   logic                  full_ff, full_in;

   // table ram
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_data;

   lrf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // fields of the entry under compare
   logic [ADDR_WIDTH-1:0] rd_src, rd_dst;
   logic [LINK_W-1:0]     rd_in_link;
   assign rd_src     = rd_data[SRC_LO +: ADDR_WIDTH];
   assign rd_dst     = rd_data[DST_LO +: ADDR_WIDTH];
   assign rd_in_link = rd_data[IN_LO +: LINK_W];

   // decision terms, valid in ST_DECIDE
   logic              tbl_full;
   logic              fwd_known;
   logic              rev_ok;
   logic [LINK_W-1:0] rev_sel;
   logic [LCW-1:0]    flood_n;
   logic [CW-1:0]     idx_next;

   assign idx_next  = idx_ff + CW'(1);
   assign tbl_full  = !fwd_found_ff && (count_ff == CW'(TABLE_DEPTH));
   assign fwd_known = fwd_found_ff && fword_ff[KNOWN_B];
   // a new pair with equal source and destination is its own reverse pair
   assign rev_ok    = rev_found_ff || (!fwd_found_ff && !tbl_full && (src_ff == dst_ff));
   assign rev_sel   = rev_found_ff ? rev_link_ff : arrive_ff;

   // flood width: zero means one link, saturate at MAX_LINKS
   always_comb begin
      if (link_count_ff == '0) begin
         flood_n = LCW'(1);
      end else if (int'(link_count_ff) > MAX_LINKS) begin
         flood_n = LCW'(MAX_LINKS);
      end else begin
         flood_n = LCW'(link_count_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      fwd_found_in  = fwd_found_ff;
      rev_found_in  = rev_found_ff;
      rsp_valid_in  = rsp_valid_ff;
      link_count_in = link_count_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      arrive_in     = arrive_ff;
      fidx_in       = fidx_ff;
      fword_in      = fword_ff;
      rev_link_in   = rev_link_ff;
      flood_cnt_in  = flood_cnt_ff;
      flood_n_in    = flood_n_ff;
      send_link_in  = send_link_ff;
      flooding_in   = flooding_ff;
      last_in       = last_ff;
      full_in       = full_ff;
      wr_en         = 1'b0;
      wr_addr       = fidx_ff;
      wr_data       = fword_ff;

      if (csr_valid) begin
         link_count_in = csr_link_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               src_in       = req_src_addr;
               dst_in       = req_dst_addr;
               arrive_in    = req_arrival_link;
               idx_in       = '0;
               fwd_found_in = 1'b0;
               rev_found_in = 1'b0;
               state_in     = (count_ff == '0) ? ST_DECIDE : ST_READ;
            end
         end
         ST_READ: begin
            // ram address is idx_ff, data shows up next cycle
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // shared compare: forward and reverse pair, first hit wins
            if (!fwd_found_ff && rd_src == src_ff && rd_dst == dst_ff) begin
               fwd_found_in = 1'b1;
               fidx_in      = idx_ff[IW-1:0];
               fword_in     = rd_data;
            end
            if (!rev_found_ff && rd_src == dst_ff && rd_dst == src_ff) begin
               rev_found_in = 1'b1;
               rev_link_in  = rd_in_link;
            end
            idx_in   = idx_next;
            state_in = (idx_next == count_ff) ? ST_DECIDE : ST_READ;
         end
         ST_DECIDE: begin
            full_in      = tbl_full;
            flood_n_in   = flood_n;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
            if (fwd_found_ff) begin
               // record the reverse link on a known pair without an out link
               if (!fword_ff[KNOWN_B] && rev_ok) begin
                  wr_en   = 1'b1;
                  wr_addr = fidx_ff;
                  wr_data = fword_ff;
                  wr_data[KNOWN_B]          = 1'b1;
                  wr_data[OUT_LO +: LINK_W] = rev_sel;
               end
            end else if (!tbl_full) begin
               // learn the new pair at the end of the table
               wr_en    = 1'b1;
               wr_addr  = count_ff[IW-1:0];
               wr_data  = {rev_ok, (rev_ok ? rev_sel : LINK_W'(0)), arrive_ff,
                           dst_ff, src_ff};
               count_in = count_ff + CW'(1);
            end
            if (fwd_known) begin
               send_link_in = fword_ff[OUT_LO +: LINK_W];
               flooding_in  = 1'b0;
               last_in      = 1'b1;
            end else if (rev_ok) begin
               send_link_in = rev_sel;
               flooding_in  = 1'b0;
               last_in      = 1'b1;
            end else begin
               flood_cnt_in = LCW'(1);
               send_link_in = LINK_W'(LCW'(1));
               flooding_in  = 1'b1;
               last_in      = (flood_n == LCW'(1));
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  // next link of the flood
                  flood_cnt_in = flood_cnt_ff + LCW'(1);
                  send_link_in = LINK_W'(flood_cnt_ff + LCW'(1));
                  last_in      = ((flood_cnt_ff + LCW'(1)) == flood_n_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         fwd_found_ff  <= 1'b0;
         rev_found_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         link_count_ff <= LINK_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         fwd_found_ff  <= fwd_found_in;
         rev_found_ff  <= rev_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         link_count_ff <= link_count_in;
      end
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      arrive_ff    <= arrive_in;
      fidx_ff      <= fidx_in;
      fword_ff     <= fword_in;
      rev_link_ff  <= rev_link_in;
      flood_cnt_ff <= flood_cnt_in;
      flood_n_ff   <= flood_n_in;
      send_link_ff <= send_link_in;
      flooding_ff  <= flooding_in;
      last_ff      <= last_in;
      full_ff      <= full_in;
   end

   // ports
   assign csr_ready      = 1'b1;
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_send_link  = send_link_ff;
   assign rsp_flooding   = flooding_ff;
   assign rsp_last       = last_ff;
   assign rsp_table_full = full_ff;

   // one header in flight: no request taken while a response is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a response is pending");

   // learned count never exceeds the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // the table grows by at most one entry, and only on a learn
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CW'(1)) && ($past(state_ff) == ST_DECIDE))
      else $error("entry count changed unexpectedly");

   // a forwarded frame gives a single response
   a_single_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_flooding |-> rsp_last)
      else $error("forwarded response without last");

endmodule : learning_route_forwarder
`default_nettype wire

>>> tb/sv/learning_route_forwarder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learning_route_forwarder_test
// self-checking bench for the learning route forwarder
// ----------------------------------------------------------------------------
// Frame headers are fed over the request channel from a queue, with random
// bursts and gaps. Responses are taken with a receiver that stalls on shifting
// patterns, with one long hold-off. A shadow route table in the bench learns
// pairs, resolves reverse pairs and floods exactly as the block should, and
// every response transaction is checked field by field against the oldest
// prediction. The link count is rewritten between phases while the block is
// idle, including the zero and saturating extremes.
// ----------------------------------------------------------------------------
module learning_route_forwarder_test;
   import lrf_pkg::*;

   localparam int CLOCK_PERIOD    = 8;
   localparam int POOL_SIZE       = 12;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT     = 5000;
   // a full table scan plus some slack
   localparam int DRAIN_CYCLES    = 2 * DEF_TABLE_DEPTH + 8;

   typedef struct packed {
      logic [DEF_ADDR_WIDTH-1:0] src_addr;
      logic [DEF_ADDR_WIDTH-1:0] dst_addr;
      logic [LINK_W-1:0]         arrival_link;
   } header_type;

   typedef struct packed {
      logic [LINK_W-1:0] send_link;
      logic              flooding;
      logic              last;
      logic              table_full;
   } route_rsp_type;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // dut ports, all inputs driven to known values from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [LINK_W-1:0]         csr_link_count = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [DEF_ADDR_WIDTH-1:0] req_src_addr = '0;
   logic [DEF_ADDR_WIDTH-1:0] req_dst_addr = '0;
   logic [LINK_W-1:0]         req_arrival_link = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [LINK_W-1:0]         rsp_send_link;
   logic                      rsp_flooding;
   logic                      rsp_last;
   logic                      rsp_table_full;

   // headers waiting to be offered, and responses the shadow table predicts
   header_type    header_queue[$];
   route_rsp_type expected_routes[$];

   // shadow route table
   logic [DEF_ADDR_WIDTH-1:0] route_src   [DEF_TABLE_DEPTH];
   logic [DEF_ADDR_WIDTH-1:0] route_dst   [DEF_TABLE_DEPTH];
   logic [LINK_W-1:0]         route_in    [DEF_TABLE_DEPTH];
   logic [LINK_W-1:0]         route_out   [DEF_TABLE_DEPTH];
   logic                      route_known [DEF_TABLE_DEPTH];
   int                        route_count = 0;
   logic [LINK_W-1:0]         flood_links = LINK_COUNT_RESET;

   logic [DEF_ADDR_WIDTH-1:0] node_pool [POOL_SIZE];

   int error_count   = 0;
   int idle_cycles   = 0;
   int burst_left    = 0;
   int gap_left      = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int mode_left     = 0;
   int rsp_phase     = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic req_fire = 1'b0;

   learning_route_forwarder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_link_count   (csr_link_count),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_addr     (req_src_addr),
      .req_dst_addr     (req_dst_addr),
      .req_arrival_link (req_arrival_link),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_send_link    (rsp_send_link),
      .rsp_flooding     (rsp_flooding),
      .rsp_last         (rsp_last),
      .rsp_table_full   (rsp_table_full)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   task automatic log_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // first learned entry matching the pair, or the table depth on a miss
   function automatic int find_route(input logic [DEF_ADDR_WIDTH-1:0] s,
                                     input logic [DEF_ADDR_WIDTH-1:0] d);
      int i;
      for (i = 0; i < route_count; i++) begin
         if (route_src[i] == s && route_dst[i] == d) return i;
      end
      return DEF_TABLE_DEPTH;
   endfunction

   function automatic route_rsp_type make_rsp(input logic [LINK_W-1:0] send_link,
                                              input logic flooding, input logic last,
                                              input logic table_full);
      route_rsp_type r;
      r.send_link  = send_link;
      r.flooding   = flooding;
      r.last       = last;
      r.table_full = table_full;
      return r;
   endfunction

   // learn, resolve and forward one header in the shadow table
   task automatic predict_forwarding(input header_type h);
      int   route;
      int   rev;
      int   n;
      int   i;
      logic full;
      full  = 1'b0;
      route = find_route(h.src_addr, h.dst_addr);
      if (route >= DEF_TABLE_DEPTH) begin
         if (route_count < DEF_TABLE_DEPTH) begin
            // new pair: incoming link known, outgoing link not yet
            route              = route_count;
            route_src[route]   = h.src_addr;
            route_dst[route]   = h.dst_addr;
            route_in[route]    = h.arrival_link;
            route_out[route]   = '0;
            route_known[route] = 1'b0;
            route_count++;
         end else begin
            full = 1'b1;
         end
      end
      if (route < DEF_TABLE_DEPTH && route_known[route]) begin
         expected_routes.push_back(make_rsp(route_out[route], 1'b0, 1'b1, full));
         return;
      end
      // reverse pair tells where the destination lives
      rev = find_route(h.dst_addr, h.src_addr);
      if (rev < DEF_TABLE_DEPTH) begin
         if (route < DEF_TABLE_DEPTH) begin
            route_out[route]   = route_in[rev];
            route_known[route] = 1'b1;
         end
         expected_routes.push_back(make_rsp(route_in[rev], 1'b0, 1'b1, full));
         return;
      end
      // unknown destination: flood, zero counts as one, large values saturate
      n = int'(flood_links);
      if (n == 0) n = 1;
      if (n > DEF_MAX_LINKS) n = DEF_MAX_LINKS;
      for (i = 1; i <= n; i++) begin
         expected_routes.push_back(make_rsp(LINK_W'(i), 1'b1, i == n, full));
      end
   endtask

   // monitor: everything is sampled at the rising edge
   always @(posedge clock) begin
      route_rsp_type want;
      if (reset) begin
         req_fire    <= 1'b0;
         route_count = 0;
         flood_links = LINK_COUNT_RESET;
      end else begin
         req_fire <= req_valid && req_ready;
         if (csr_valid && csr_ready) flood_links = csr_link_count;
         // check the response transaction before predicting a new header
         if (rsp_valid && rsp_ready) begin
            if (expected_routes.size() == 0) begin
               log_mismatch($sformatf("unexpected response link %0d flood %0b last %0b",
                                      rsp_send_link, rsp_flooding, rsp_last));
            end else begin
               want = expected_routes.pop_front();
               if (rsp_send_link !== want.send_link)
                  log_mismatch($sformatf("send_link %0d, wanted %0d",
                                         rsp_send_link, want.send_link));
               if (rsp_flooding !== want.flooding)
                  log_mismatch($sformatf("flooding %0b, wanted %0b",
                                         rsp_flooding, want.flooding));
               if (rsp_last !== want.last)
                  log_mismatch($sformatf("last %0b, wanted %0b", rsp_last, want.last));
               if (rsp_table_full !== want.table_full)
                  log_mismatch($sformatf("table_full %0b, wanted %0b",
                                         rsp_table_full, want.table_full));
            end
         end
         if (req_valid && req_ready)
            predict_forwarding(header_type'{req_src_addr, req_dst_addr, req_arrival_link});
      end
   end

   // watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // request driver: bursts of headers separated by random gaps
   always @(negedge clock) begin
      header_type next_header;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (header_queue.size() > 0) begin
            next_header = header_queue.pop_front();
            req_src_addr     <= next_header.src_addr;
            req_dst_addr     <= next_header.dst_addr;
            req_arrival_link <= next_header.arrival_link;
            req_valid        <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // new burst; a third of them run back to back
               burst_left = int'($urandom_range(0, 23));
               case ($urandom_range(0, 5))
                  0, 1:    gap_left = 0;
                  2:       gap_left = int'($urandom_range(20, 60));
                  default: gap_left = int'($urandom_range(1, 12));
               endcase
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver: its own stall pattern, plus long hold-offs on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = RSP_HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = int'($urandom_range(16, 96));
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               STALL_NONE:  rsp_ready <= 1'b1;
               STALL_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ready <= ((rsp_phase % 7) < 3);
            endcase
         end
         rsp_phase++;
      end
   end

   task automatic queue_header(input logic [DEF_ADDR_WIDTH-1:0] s,
                               input logic [DEF_ADDR_WIDTH-1:0] d,
                               input logic [LINK_W-1:0] arrival);
      header_queue.push_back(header_type'{s, d, arrival});
   endtask

   // block until the sender has drained and every response has arrived
   task automatic wait_idle;
      do begin
         @(posedge clock);
         #1;
      end while (header_queue.size() != 0 || req_valid || expected_routes.size() != 0);
   endtask

   // single csr transaction, issued only while the block is idle
   task automatic write_link_count(input logic [LINK_W-1:0] value);
      @(negedge clock);
      csr_link_count <= value;
      csr_valid      <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      #1;
   endtask

   // mostly short conversations between pool nodes, some random noise
   task automatic queue_traffic(input int count);
      logic [DEF_ADDR_WIDTH-1:0] a;
      logic [DEF_ADDR_WIDTH-1:0] b;
      int turns;
      int j;
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) < 2) begin
            queue_header(DEF_ADDR_WIDTH'($urandom), DEF_ADDR_WIDTH'($urandom),
                         LINK_W'($urandom_range(0, 63)));
            n++;
         end else begin
            a     = node_pool[$urandom_range(0, POOL_SIZE - 1)];
            b     = node_pool[$urandom_range(0, POOL_SIZE - 1)];
            turns = int'($urandom_range(1, 4));
            // alternate directions so reverse lookups get resolved
            for (j = 0; j < turns; j++) begin
               if (j % 2 == 0) begin
                  queue_header(a, b, ($urandom_range(0, 9) == 0) ?
                               LINK_W'($urandom_range(0, 63)) :
                               LINK_W'($urandom_range(1, 32)));
               end else begin
                  queue_header(b, a, ($urandom_range(0, 9) == 0) ?
                               LINK_W'($urandom_range(0, 63)) :
                               LINK_W'($urandom_range(1, 32)));
               end
               n++;
            end
         end
      end
   endtask

   initial begin
      int k;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (k = 0; k < POOL_SIZE; k++) node_pool[k] = DEF_ADDR_WIDTH'($urandom);

      // directed part at the reset link count of four
      queue_header(16'h0000, 16'hFFFF, 6'd1);   // new pair, no reverse: flood
      queue_header(16'hFFFF, 16'h0000, 6'd32);  // reverse known: forward on 1
      queue_header(16'h0000, 16'hFFFF, 6'd5);   // resolve via reverse: link 32
      queue_header(16'h0000, 16'hFFFF, 6'd7);   // outgoing link already known
      queue_header(16'hFFFF, 16'h0000, 6'd3);   // known the other way
      queue_header(16'h1234, 16'h1234, 6'd2);   // source equals destination
      queue_header(16'hA5A5, 16'h5A5A, 6'd63);  // arrival link out of range
      queue_header(16'h5A5A, 16'hA5A5, 6'd0);   // forwards on link 63
      queue_header(16'hA5A5, 16'h5A5A, 6'd1);   // forwards on link 0
      wait_idle();

      // flood width extremes, zero and above the link maximum included
      write_link_count(6'd1);
      queue_header(16'h00F0, 16'h0F00, 6'd9);
      wait_idle();
      write_link_count(6'd32);
      queue_header(16'h3C3C, 16'hC3C3, 6'd32);
      wait_idle();
      write_link_count(6'd0);
      queue_header(16'h8000, 16'h0001, 6'd16);
      wait_idle();
      write_link_count(6'd63);
      queue_header(16'h7FFF, 16'hFFFE, 6'd31);
      wait_idle();

      // wide floods behind a long receiver hold-off, so the input backs up
      write_link_count(6'd32);
      hold_requests++;
      queue_traffic(40);
      wait_idle();

      write_link_count(6'd1);
      queue_traffic(70);
      wait_idle();

      // mid-phase the sender stops until every response is back
      write_link_count(LINK_W'($urandom_range(2, 31)));
      queue_traffic(30);
      wait_idle();
      queue_traffic(30);
      wait_idle();

      write_link_count(6'd0);
      queue_traffic(60);
      wait_idle();

      write_link_count(LINK_W'($urandom_range(33, 63)));
      queue_traffic(50);
      wait_idle();

      write_link_count(LINK_COUNT_RESET);
      queue_traffic(70);
      wait_idle();

      write_link_count(LINK_W'($urandom_range(1, 63)));
      queue_traffic(50);
      wait_idle();

      // let any stray response show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_routes.size() != 0)
         log_mismatch($sformatf("%0d responses never arrived", expected_routes.size()));
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule : learning_route_forwarder_test
